// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is asserted (active-low reset).
`define ODO_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("odometry assertion failed");

// Clocked assertion that is checked during reset as well.
`define ODO_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("odometry assertion failed");

`endif

// ===== rtl/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// odo_pkg
// Types, constants and helper functions of the wheel odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

  // Default values of the top-level parameters.
  localparam int ENCODER_BITS_DEF = 15;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_ITERS_DEF = 18;

  // Fixed field widths.
  localparam int DATA_W     = 32;
  localparam int TIME_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int RADIUS_W   = 16;
  localparam int TRACK_W    = 17;
  localparam int CPR_W      = 16;

  // Shared datapath widths.
  localparam int OPD_W      = 34;  // multiplier operands
  localparam int PROD_W     = 64;  // product register
  localparam int DIVN_W     = 64;  // dividend / quotient
  localparam int DIVD_W     = 34;  // divisor / remainder
  localparam int XY_W       = 64;  // CORDIC x and y
  localparam int Z_W        = 34;  // CORDIC angle, Q30
  localparam int ANG_W      = 36;  // angle reduction
  localparam int ATAN_IDX_W = 5;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_TRACK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 2'd2;

  // Register reset values.
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd5571;
  localparam logic [TRACK_W-1:0]  TRACK_RST  = 17'd18547;
  localparam logic [CPR_W-1:0]    CPR_RST    = 16'd756;

  // Arithmetic constants.
  localparam logic signed [OPD_W-1:0] TWO_PI_Q29      = 34'sd3373259426;
  localparam logic signed [OPD_W-1:0] US_PER_S        = 34'sd1000000;
  localparam logic [DIVD_W-1:0]       TWO_PI_Q30_U    = 34'd6746518852;
  localparam logic signed [ANG_W-1:0] PI_Q30          = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30      = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30     = 36'sd1686629713;
  localparam logic signed [XY_W-1:0]  CORDIC_GAIN_Q30 = 64'sd652032874;
  localparam logic [TIME_W-1:0]       MIN_US          = 24'd100;
  localparam int                      WRAP_LOW        = 1000;
  localparam int                      WRAP_DIST       = 1768;

  // Reciprocal of 2*pi in Q30, scaled by 2^59 and rounded down. The quotient
  // estimate it gives is at most one below the true quotient.
  localparam logic signed [OPD_W-1:0] HMOD_RECIP       = 34'sd85445659;
  localparam int                      HMOD_RECIP_SHIFT = 59;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TTR_MUL,
    ST_TTR_DGO,
    ST_TTR_DWAIT,
    ST_DIST_L,
    ST_DIST_R,
    ST_DIST_W,
    ST_AVG,
    ST_ATAN_GO,
    ST_ATAN_WAIT,
    ST_HMOD_MUL,
    ST_HMOD_QMUL,
    ST_HMOD_SUB,
    ST_HMOD_FOLD,
    ST_ROT_GO,
    ST_ROT_WAIT,
    ST_PX_MUL,
    ST_PY_MUL,
    ST_PY_ADD,
    ST_RATE_MUL,
    ST_RATE_DGO,
    ST_RATE_DWAIT,
    ST_DONE
  } state_t;

  typedef enum logic {
    CORDIC_VECTOR,
    CORDIC_ROTATE
  } cordic_mode_t;

  typedef struct packed {
    logic         start;
    cordic_mode_t mode;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
    logic signed [Z_W-1:0] a;
    case (i)
      5'd0:    a = 34'sd843314857;
      5'd1:    a = 34'sd497837829;
      5'd2:    a = 34'sd263043837;
      5'd3:    a = 34'sd133525159;
      5'd4:    a = 34'sd67021687;
      5'd5:    a = 34'sd33543516;
      5'd6:    a = 34'sd16775851;
      5'd7:    a = 34'sd8388437;
      5'd8:    a = 34'sd4194283;
      5'd9:    a = 34'sd2097149;
      5'd10:   a = 34'sd1048575;
      5'd11:   a = 34'sd524288;
      5'd12:   a = 34'sd262144;
      5'd13:   a = 34'sd131072;
      5'd14:   a = 34'sd65536;
      5'd15:   a = 34'sd32768;
      5'd16:   a = 34'sd16384;
      5'd17:   a = 34'sd8192;
      5'd18:   a = 34'sd4096;
      5'd19:   a = 34'sd2048;
      5'd20:   a = 34'sd1024;
      5'd21:   a = 34'sd512;
      5'd22:   a = 34'sd256;
      5'd23:   a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Right shift by a constant amount, rounding half away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned sh);
    logic [63:0] m;
    logic [63:0] q;
    m = v[63] ? 64'(-v) : 64'(v);
    q = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  // Apply a sign to a magnitude and saturate to 32 bit signed.
  function automatic logic signed [DATA_W-1:0] sat32(input logic [DIVN_W-1:0] q,
                                                     input logic neg);
    logic signed [DATA_W-1:0] r;
    if (!neg) begin
      r = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end else begin
      r = (q > 64'h8000_0000) ? 32'sh8000_0000 : $signed(32'(-q));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/odo_if.sv =====
// ----------------------------------------------------------------------------
// odo_if
// Valid/ready channel interfaces: samples in, results out, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface odo_in_if import odo_pkg::*; #(parameter int ENC_W = ENCODER_BITS_DEF) ();
  logic              valid;
  logic              ready;
  logic [ENC_W-1:0]  left_count;
  logic [ENC_W-1:0]  right_count;
  logic [TIME_W-1:0] elapsed_us;

  modport source(output valid, left_count, right_count, elapsed_us, input ready);
  modport sink(input valid, left_count, right_count, elapsed_us, output ready);
endinterface

interface odo_out_if import odo_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] left_angle;
  logic signed [DATA_W-1:0] right_angle;
  logic signed [DATA_W-1:0] left_rate;
  logic signed [DATA_W-1:0] right_rate;
  logic signed [DATA_W-1:0] pose_x;
  logic signed [DATA_W-1:0] pose_y;
  logic signed [DATA_W-1:0] heading_out;
  logic signed [DATA_W-1:0] forward_speed;
  logic signed [DATA_W-1:0] turn_rate;

  modport source(output valid, left_angle, right_angle, left_rate, right_rate, pose_x,
                 pose_y, heading_out, forward_speed, turn_rate, input ready);
  modport sink(input valid, left_angle, right_angle, left_rate, right_rate, pose_x,
               pose_y, heading_out, forward_speed, turn_rate, output ready);
endinterface

interface odo_cfg_if import odo_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/odo_div.sv =====
// ----------------------------------------------------------------------------
// odo_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_div import odo_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DIVN_W-1:0]   num,
  input  wire logic [DIVD_W-1:0]   den,
  output logic      [DIVN_W-1:0]   quot,
  output unit_status_t             status
);

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic [DIVN_W-1:0] quot_r;
  logic [DIVD_W:0]   rem_r;
  logic [DIVD_W-1:0] den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVD_W:0]   trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try the divisor.
  always_comb begin
    trial = {rem_r[DIVD_W-1:0], quot_r[DIVN_W-1]};
    fits  = trial >= {1'b0, den_r};
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      quot_r <= {quot_r[DIVN_W-2:0], fits};
      rem_r  <= fits ? (trial - {1'b0, den_r}) : trial;
    end
  end

  assign quot        = quot_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

`default_nettype wire

// ===== rtl/odo_cordic.sv =====
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_cordic import odo_pkg::*; #(
  parameter int ITERS = CORDIC_ITERS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cordic_ctl_t            ctl,
  input  wire logic signed [XY_W-1:0] x0,
  input  wire logic signed [XY_W-1:0] y0,
  input  wire logic signed [Z_W-1:0]  z0,
  output logic signed [XY_W-1:0]      x,
  output logic signed [XY_W-1:0]      y,
  output logic signed [Z_W-1:0]       z,
  output unit_status_t                status
);

  localparam int CNT_W = $clog2(ITERS);

  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]  z_r;
  logic [CNT_W-1:0]       i_r;
  cordic_mode_t           mode_r;
  logic                   busy_r;
  logic                   done_r;
  logic signed [XY_W-1:0] sx, sy, x_step, y_step;
  logic signed [Z_W-1:0]  a, z_step;

  // One micro-rotation.
  always_comb begin
    sx = x_r >>> i_r;
    sy = y_r >>> i_r;
    a  = atan_q30(ATAN_IDX_W'(i_r));
    if (mode_r == CORDIC_VECTOR) begin
      if (y_r > 0) begin
        x_step = x_r + sy;
        y_step = y_r - sx;
        z_step = z_r + a;
      end else begin
        x_step = x_r - sy;
        y_step = y_r + sx;
        z_step = z_r - a;
      end
    end else begin
      if (z_r >= 0) begin
        x_step = x_r - sy;
        y_step = y_r + sx;
        z_step = z_r - a;
      end else begin
        x_step = x_r + sy;
        y_step = y_r - sx;
        z_step = z_r + a;
      end
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        if (i_r == CNT_W'(ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
    end
  end

  // Vector and angle registers.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r    <= x0;
      y_r    <= y0;
      z_r    <= z0;
      mode_r <= ctl.mode;
    end else if (busy_r) begin
      x_r <= x_step;
      y_r <= y_step;
      z_r <= z_step;
    end
  end

  assign x           = x_r;
  assign y           = y_r;
  assign z           = z_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

`default_nettype wire

// ===== rtl/diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive wheel odometry: wheel angles, rates, pose and speeds.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   left_count, right_count, elapsed_us
//   out_ch   out  valid/ready   angles, rates, pose, heading, speed, turn rate
//   cfg_ch   in   valid/ready   index, data (always ready)
//
// While a sample is processed the sequencer stays busy: eight divisions on the
// shared radix-2 divider, each behind a multiplier step, two CORDIC runs and
// single steps of products, heading reduction and sums. Equal wheel distances
// skip the arctangent run.
// in_ch is ready only in the idle state; a finished result waits in the output
// register, and the next sample runs meanwhile until its own result is due.
// Reset is synchronous and clears the pose, the previous counts and the
// registers to their defaults.
`default_nettype none

module diff_drive_odometry import odo_pkg::*; #(
  parameter int ENCODER_BITS = ENCODER_BITS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  odo_in_if.sink    in_ch,
  odo_out_if.source out_ch,
  odo_cfg_if.sink   cfg_ch
);

  localparam int D_W       = ENCODER_BITS + 2;
  localparam int ENC_SPAN  = 1 << ENCODER_BITS;
  localparam int WRAP_HIGH = ENC_SPAN - WRAP_DIST;
  localparam int DEN_SHIFT = 29 - FRAC_BITS;
  localparam int Q30_SHIFT = 30 - FRAC_BITS;

  // Signed tick delta with counter wrap handling.
  function automatic logic signed [D_W-1:0] tick_delta(input logic [ENCODER_BITS-1:0] p,
                                                       input logic [ENCODER_BITS-1:0] c);
    logic signed [D_W-1:0] ps;
    logic signed [D_W-1:0] cs;
    logic signed [D_W-1:0] d;
    ps = $signed({2'b00, p});
    cs = $signed({2'b00, c});
    if (ps < D_W'(WRAP_LOW) && cs > D_W'(WRAP_HIGH)) begin
      d = cs - ps - D_W'(ENC_SPAN);
    end else if (ps > D_W'(WRAP_HIGH) && cs < D_W'(WRAP_LOW)) begin
      d = D_W'(ENC_SPAN) - ps + cs;
    end else begin
      d = cs - ps;
    end
    return d;
  endfunction

  // Magnitude of a 32-bit value in operand width.
  function automatic logic signed [OPD_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    logic signed [OPD_W-1:0] e;
    e = OPD_W'(v);
    return v[DATA_W-1] ? -e : e;
  endfunction

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [RADIUS_W-1:0] radius_r;
  logic [TRACK_W-1:0]  track_r;
  logic [CPR_W-1:0]    cpr_r;

  // Odometry state.
  logic [ENCODER_BITS-1:0] prev_l_r, prev_r_r;
  logic                    have_prev_r;
  logic signed [DATA_W-1:0] acc_x_r, acc_y_r, acc_h_r;

  // Per-sample working registers.
  logic [ENCODER_BITS-1:0]  lc_r, rc_r;
  logic [TIME_W-1:0]        t_r;
  logic signed [D_W-1:0]    tl_r, tr_r;
  logic [1:0]               idx_r;
  logic                     neg_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DATA_W-1:0] ttr_r [4];
  logic signed [DATA_W-1:0] rate_r [4];
  logic signed [OPD_W-1:0]  dleft_r, dright_r, avg_r, diff_r, cos_r, sin_r;
  logic signed [DATA_W-1:0] dang_r;
  logic signed [ANG_W-1:0]  red_r;
  logic                     flip_r;

  // Output register.
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] o_la_r, o_ra_r, o_lr_r, o_rr_r, o_x_r, o_y_r, o_h_r;
  logic signed [DATA_W-1:0] o_v_r, o_w_r;

  // Shared units and their hookup.
  logic                     in_xfer, out_xfer, out_load;
  logic                     div_start;
  logic [DIVN_W-1:0]        div_num, div_quot;
  logic [DIVD_W-1:0]        div_den;
  unit_status_t             div_st, cor_st;
  cordic_ctl_t              cor_ctl;
  logic signed [XY_W-1:0]   cor_x0, cor_y0, cor_x, cor_y;
  logic signed [Z_W-1:0]    cor_z0, cor_z;
  logic signed [OPD_W-1:0]  mul_a, mul_b;
  logic signed [2*OPD_W-1:0] mul_p;
  logic [CPR_W-1:0]         cpr_eff;
  logic [DIVD_W-1:0]        den_ttr;
  logic signed [OPD_W-1:0]  ttr_src, rate_src;
  logic signed [OPD_W-1:0]  diff_mag;
  logic signed [OPD_W-1:0]  sum_lr;
  logic [DIVN_W-1:0]        hmod_num, hmod_rem;
  logic signed [ANG_W-1:0]  fold_ang;
  logic                     fold_flip;
  logic signed [63:0]       z_rnd;
  logic [TIME_W-1:0]        t_in;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      track_r  <= TRACK_RST;
      cpr_r    <= CPR_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_WHEEL_RADIUS:   radius_r <= cfg_ch.data[RADIUS_W-1:0];
        REG_WHEEL_TRACK:    track_r  <= cfg_ch.data[TRACK_W-1:0];
        REG_COUNTS_PER_REV: cpr_r    <= cfg_ch.data[CPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand selection.
  always_comb begin
    cpr_eff  = (cpr_r == '0) ? CPR_W'(1) : cpr_r;
    den_ttr  = DIVD_W'(cpr_eff) << DEN_SHIFT;
    t_in     = (in_ch.elapsed_us < MIN_US) ? MIN_US : in_ch.elapsed_us;
    diff_mag = diff_r[OPD_W-1] ? -diff_r : diff_r;
    sum_lr   = dleft_r + dright_r;
    case (idx_r)
      2'd0:    ttr_src = OPD_W'($signed({2'b00, lc_r}));
      2'd1:    ttr_src = OPD_W'($signed({2'b00, rc_r}));
      2'd2:    ttr_src = OPD_W'(tl_r);
      default: ttr_src = OPD_W'(tr_r);
    endcase
    case (idx_r)
      2'd0:    rate_src = OPD_W'(ttr_r[2]);
      2'd1:    rate_src = OPD_W'(ttr_r[3]);
      2'd2:    rate_src = avg_r;
      default: rate_src = OPD_W'(dang_r);
    endcase
    // Heading magnitude in Q30 less the quotient estimate times 2*pi, with
    // one correction step.
    hmod_num = DIVN_W'(mag32(acc_h_r)) << Q30_SHIFT;
    hmod_rem = hmod_num - DIVN_W'(prod_r);
    if (hmod_rem >= DIVN_W'(TWO_PI_Q30_U)) begin
      hmod_rem = hmod_rem - DIVN_W'(TWO_PI_Q30_U);
    end
  end

  // Shared multiplier input.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_TTR_MUL: begin
        mul_a = ttr_src[OPD_W-1] ? -ttr_src : ttr_src;
        mul_b = TWO_PI_Q29;
      end
      ST_DIST_L: begin
        mul_a = OPD_W'(ttr_r[2]);
        mul_b = $signed({18'd0, radius_r});
      end
      ST_DIST_R: begin
        mul_a = OPD_W'(ttr_r[3]);
        mul_b = $signed({18'd0, radius_r});
      end
      ST_HMOD_MUL: begin
        mul_a = mag32(acc_h_r);
        mul_b = HMOD_RECIP;
      end
      ST_HMOD_QMUL: begin
        mul_a = OPD_W'(prod_r >>> (HMOD_RECIP_SHIFT - Q30_SHIFT));
        mul_b = $signed(TWO_PI_Q30_U);
      end
      ST_PX_MUL: begin
        mul_a = avg_r;
        mul_b = cos_r;
      end
      ST_PY_MUL: begin
        mul_a = avg_r;
        mul_b = sin_r;
      end
      ST_RATE_MUL: begin
        mul_a = rate_src[OPD_W-1] ? -rate_src : rate_src;
        mul_b = US_PER_S;
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Angle reduction of the old heading into [-pi/2, pi/2] with a flip flag.
  always_comb begin
    fold_ang  = red_r;
    fold_flip = 1'b0;
    if (fold_ang < 0) begin
      fold_ang = fold_ang + TWO_PI_Q30;
    end
    if (fold_ang > PI_Q30) begin
      fold_ang = fold_ang - TWO_PI_Q30;
    end
    if (fold_ang > HALF_PI_Q30) begin
      fold_ang  = fold_ang - PI_Q30;
      fold_flip = 1'b1;
    end else if (fold_ang < -HALF_PI_Q30) begin
      fold_ang  = fold_ang + PI_Q30;
      fold_flip = 1'b1;
    end
    z_rnd = rnd_shr(64'(cor_z), Q30_SHIFT);
  end

  // Sequencer: next state and unit controls.
  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    cor_ctl      = '{start: 1'b0, mode: CORDIC_VECTOR};
    cor_x0       = '0;
    cor_y0       = '0;
    cor_z0       = '0;
    case (state_r)
      ST_IDLE:      if (in_xfer) state_nxt = ST_TTR_MUL;
      ST_TTR_MUL:   state_nxt = ST_TTR_DGO;
      ST_TTR_DGO: begin
        div_start = 1'b1;
        div_num   = DIVN_W'(prod_r) + DIVN_W'(den_ttr >> 1);
        div_den   = den_ttr;
        state_nxt = ST_TTR_DWAIT;
      end
      ST_TTR_DWAIT: begin
        if (div_st.done) state_nxt = (idx_r == 2'd3) ? ST_DIST_L : ST_TTR_MUL;
      end
      ST_DIST_L:    state_nxt = ST_DIST_R;
      ST_DIST_R:    state_nxt = ST_DIST_W;
      ST_DIST_W:    state_nxt = ST_AVG;
      ST_AVG:       state_nxt = ST_ATAN_GO;
      ST_ATAN_GO: begin
        if (diff_r == '0) begin
          state_nxt = ST_HMOD_MUL;
        end else begin
          cor_ctl   = '{start: 1'b1, mode: CORDIC_VECTOR};
          cor_x0    = XY_W'(track_r) << FRAC_BITS;
          cor_y0    = XY_W'(diff_mag) << 16;
          state_nxt = ST_ATAN_WAIT;
        end
      end
      ST_ATAN_WAIT: if (cor_st.done) state_nxt = ST_HMOD_MUL;
      ST_HMOD_MUL:  state_nxt = ST_HMOD_QMUL;
      ST_HMOD_QMUL: state_nxt = ST_HMOD_SUB;
      ST_HMOD_SUB:  state_nxt = ST_HMOD_FOLD;
      ST_HMOD_FOLD: state_nxt = ST_ROT_GO;
      ST_ROT_GO: begin
        cor_ctl   = '{start: 1'b1, mode: CORDIC_ROTATE};
        cor_x0    = CORDIC_GAIN_Q30;
        cor_y0    = '0;
        cor_z0    = red_r[Z_W-1:0];
        state_nxt = ST_ROT_WAIT;
      end
      ST_ROT_WAIT:  if (cor_st.done) state_nxt = ST_PX_MUL;
      ST_PX_MUL:    state_nxt = ST_PY_MUL;
      ST_PY_MUL:    state_nxt = ST_PY_ADD;
      ST_PY_ADD:    state_nxt = ST_RATE_MUL;
      ST_RATE_MUL:  state_nxt = ST_RATE_DGO;
      ST_RATE_DGO: begin
        div_start = 1'b1;
        div_num   = DIVN_W'(prod_r) + DIVN_W'(t_r >> 1);
        div_den   = DIVD_W'(t_r);
        state_nxt = ST_RATE_DWAIT;
      end
      ST_RATE_DWAIT: begin
        if (div_st.done) state_nxt = (idx_r == 2'd3) ? ST_DONE : ST_RATE_MUL;
      end
      ST_DONE:      if (out_load) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Odometry state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      have_prev_r <= 1'b0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_h_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        prev_l_r    <= in_ch.left_count[ENCODER_BITS-1:0];
        prev_r_r    <= in_ch.right_count[ENCODER_BITS-1:0];
        have_prev_r <= 1'b1;
      end
      if (state_r == ST_PY_MUL) begin
        acc_x_r <= acc_x_r + DATA_W'(rnd_shr(prod_r, 30));
      end
      if (state_r == ST_PY_ADD) begin
        acc_y_r <= acc_y_r + DATA_W'(rnd_shr(prod_r, 30));
        acc_h_r <= acc_h_r + dang_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working datapath.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lc_r  <= in_ch.left_count[ENCODER_BITS-1:0];
      rc_r  <= in_ch.right_count[ENCODER_BITS-1:0];
      t_r   <= t_in;
      tl_r  <= have_prev_r ? tick_delta(prev_l_r, in_ch.left_count[ENCODER_BITS-1:0]) : '0;
      tr_r  <= have_prev_r ? tick_delta(prev_r_r, in_ch.right_count[ENCODER_BITS-1:0]) : '0;
      idx_r <= 2'd0;
    end
    case (state_r)
      ST_TTR_MUL: begin
        prod_r <= mul_p[PROD_W-1:0];
        neg_r  <= ttr_src[OPD_W-1];
      end
      ST_TTR_DWAIT: begin
        if (div_st.done) begin
          ttr_r[idx_r] <= sat32(div_quot, neg_r);
          idx_r        <= idx_r + 2'd1;
        end
      end
      ST_DIST_L:  prod_r <= mul_p[PROD_W-1:0];
      ST_DIST_R: begin
        dleft_r <= OPD_W'(-rnd_shr(prod_r, 16));
        prod_r  <= mul_p[PROD_W-1:0];
      end
      ST_DIST_W:  dright_r <= OPD_W'(rnd_shr(prod_r, 16));
      ST_AVG: begin
        avg_r  <= OPD_W'(rnd_shr(64'(sum_lr), 1));
        diff_r <= dright_r - dleft_r;
      end
      ST_ATAN_GO: begin
        neg_r  <= diff_r[OPD_W-1];
        dang_r <= '0;
      end
      ST_ATAN_WAIT: begin
        if (cor_st.done) dang_r <= neg_r ? -z_rnd[DATA_W-1:0] : z_rnd[DATA_W-1:0];
      end
      ST_HMOD_MUL: begin
        prod_r <= mul_p[PROD_W-1:0];
        neg_r  <= acc_h_r[DATA_W-1];
      end
      ST_HMOD_QMUL: prod_r <= mul_p[PROD_W-1:0];
      ST_HMOD_SUB: begin
        red_r <= neg_r ? -$signed(ANG_W'(hmod_rem)) : $signed(ANG_W'(hmod_rem));
      end
      ST_HMOD_FOLD: begin
        red_r  <= fold_ang;
        flip_r <= fold_flip;
      end
      ST_ROT_WAIT: begin
        if (cor_st.done) begin
          cos_r <= flip_r ? -OPD_W'(cor_x) : OPD_W'(cor_x);
          sin_r <= flip_r ? -OPD_W'(cor_y) : OPD_W'(cor_y);
        end
      end
      ST_PX_MUL:  prod_r <= mul_p[PROD_W-1:0];
      ST_PY_MUL:  prod_r <= mul_p[PROD_W-1:0];
      ST_PY_ADD:  idx_r  <= 2'd0;
      ST_RATE_MUL: begin
        prod_r <= mul_p[PROD_W-1:0];
        neg_r  <= rate_src[OPD_W-1];
      end
      ST_RATE_DWAIT: begin
        if (div_st.done) begin
          rate_r[idx_r] <= sat32(div_quot, neg_r);
          idx_r         <= idx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_la_r <= ttr_r[0];
      o_ra_r <= ttr_r[1];
      o_lr_r <= rate_r[0];
      o_rr_r <= rate_r[1];
      o_x_r  <= acc_x_r;
      o_y_r  <= acc_y_r;
      o_h_r  <= acc_h_r;
      o_v_r  <= rate_r[2];
      o_w_r  <= rate_r[3];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_angle    = o_la_r;
  assign out_ch.right_angle   = o_ra_r;
  assign out_ch.left_rate     = o_lr_r;
  assign out_ch.right_rate    = o_rr_r;
  assign out_ch.pose_x        = o_x_r;
  assign out_ch.pose_y        = o_y_r;
  assign out_ch.heading_out   = o_h_r;
  assign out_ch.forward_speed = o_v_r;
  assign out_ch.turn_rate     = o_w_r;

  // Shared divider.
  odo_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quot   (div_quot),
    .status (div_st)
  );

  // Shared CORDIC.
  odo_cordic #(
    .ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cor_ctl),
    .x0     (cor_x0),
    .y0     (cor_y0),
    .z0     (cor_z0),
    .x      (cor_x),
    .y      (cor_y),
    .z      (cor_z),
    .status (cor_st)
  );

endmodule

`default_nettype wire

// ===== rtl/odo_checker.sv =====
// ----------------------------------------------------------------------------
// odo_checker
// Port-level checks of the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module odo_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_pose_x,
  input wire logic        cfg_ready
);

  // A sample transfer starts a computation, so the input closes right after.
  `ODO_ASSERT(a_busy_after_in, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  // Reset leaves no result pending.
  `ODO_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)
  // The register port never stalls.
  `ODO_ASSERT(a_cfg_ready, clk, rst_n, cfg_ready)
  // A stalled result stays offered, and its pose_x stays unchanged.
  `ODO_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
  `ODO_ASSERT(a_out_stable, clk, rst_n, (out_valid && !out_ready) |=> $stable(out_pose_x))

endmodule

bind diff_drive_odometry odo_checker u_odo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_pose_x (out_ch.pose_x),
  .cfg_ready  (cfg_ch.ready)
);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for diff_drive_odometry. A bit-accurate predictor of
// the wheel odometry runs beside the block; every result transfer is compared
// field by field against the oldest predicted pose, under random stalls on
// both channels, several register settings and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import odo_pkg::*;

  localparam int ENC_W       = ENCODER_BITS_DEF;
  localparam int WATCH_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 800;
  localparam int HOLD_LEN    = 4000;

  localparam longint ENC_SPAN    = 64'd1 << ENC_W;
  localparam longint TWO_PI_29   = 64'd3373259426;
  localparam longint PI_30       = 64'd3373259426;
  localparam longint TWO_PI_30   = 64'd6746518852;
  localparam longint HALF_PI_30  = 64'd1686629713;
  localparam longint GAIN_30     = 64'd652032874;
  localparam longint ATAN_TAB [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048575, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  typedef logic [8:0][DATA_W-1:0] pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  odo_in_if  in_if();
  odo_out_if out_if();
  odo_cfg_if cfg_if();

  diff_drive_odometry dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #5 clk = ~clk;

  // Predictor state and register copies.
  logic [RADIUS_W-1:0] radius_q = RADIUS_RST;
  logic [TRACK_W-1:0]  track_q  = TRACK_RST;
  logic [CPR_W-1:0]    cpr_q    = CPR_RST;
  logic [ENC_W-1:0]    last_left, last_right;
  logic                seen_sample;
  logic [31:0]         pos_x, pos_y, heading;

  pose_t pending_poses[$];
  int    mismatches = 0;
  int    send_idle = 0;
  int    recv_idle = 0;
  int    idle_watch = 0;
  bit    hold_req = 0;
  int    hold_left = 0;
  logic [ENC_W-1:0] stim_left = '0, stim_right = '0;

  string field_names [9] = '{"left_angle", "right_angle", "left_rate", "right_rate",
                             "pose_x", "pose_y", "heading_out", "forward_speed",
                             "turn_rate"};

  // Division rounding half away from zero.
  function automatic longint rnd_div(longint n, longint unsigned d);
    longint unsigned m;
    longint unsigned q;
    m = (n < 0) ? longint'(-n) : longint'(n);
    q = (m + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint ticks_rad(longint ticks);
    longint unsigned cpr;
    longint unsigned m;
    longint unsigned den;
    longint unsigned q;
    cpr = (cpr_q == 0) ? 1 : cpr_q;
    m = (ticks < 0) ? longint'(-ticks) : longint'(ticks);
    den = cpr << (29 - FRAC_BITS_DEF);
    q = (m * TWO_PI_29 + den / 2) / den;
    return clip32((ticks < 0) ? -longint'(q) : longint'(q));
  endfunction

  // Encoder step with counter wrap in either direction.
  function automatic longint tick_step(longint prev, longint cur);
    if (prev < WRAP_LOW && cur > ENC_SPAN - WRAP_DIST) return cur - prev - ENC_SPAN;
    if (prev > ENC_SPAN - WRAP_DIST && cur < WRAP_LOW) return ENC_SPAN - prev + cur;
    return cur - prev;
  endfunction

  // Vectoring arctangent of the distance difference over the track.
  function automatic longint turn_angle(longint num, longint track);
    longint x, y, z, xn;
    if (num == 0) return 0;
    x = track <<< FRAC_BITS_DEF;
    y = ((num < 0) ? -num : num) <<< 16;
    z = 0;
    for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
      if (y > 0) begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_TAB[i];
      end else begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_TAB[i];
      end
      x = xn;
    end
    z = rnd_div(z, 64'd1 << (30 - FRAC_BITS_DEF));
    return (num < 0) ? -z : z;
  endfunction

  // Rotation CORDIC giving cos and sin of the heading in Q30.
  task automatic heading_trig(input longint ang, output longint c, output longint s);
    longint r, x, y, xn;
    bit flip;
    r = (ang * (64'sd1 << (30 - FRAC_BITS_DEF))) % TWO_PI_30;
    x = GAIN_30;
    y = 0;
    flip = 0;
    if (r < 0) r += TWO_PI_30;
    if (r > PI_30) r -= TWO_PI_30;
    if (r > HALF_PI_30) begin
      r -= PI_30;
      flip = 1;
    end else if (r < -HALF_PI_30) begin
      r += PI_30;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_ITERS_DEF; i++) begin
      if (r >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        r -= ATAN_TAB[i];
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        r += ATAN_TAB[i];
      end
      x = xn;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Advance the odometry by one sample and return the expected result.
  task automatic odometry_step(input logic [ENC_W-1:0] lc, input logic [ENC_W-1:0] rc,
                               input logic [TIME_W-1:0] us, output pose_t res);
    longint t, dl, dr, d_left, d_right, avg, dang, c, s;
    t = (us < MIN_US) ? MIN_US : us;
    dl = 0;
    dr = 0;
    if (seen_sample) begin
      dl = ticks_rad(tick_step(last_left, lc));
      dr = ticks_rad(tick_step(last_right, rc));
    end
    last_left = lc;
    last_right = rc;
    seen_sample = 1'b1;
    d_left  = -rnd_div(dl * longint'(radius_q), 65536);
    d_right = rnd_div(dr * longint'(radius_q), 65536);
    avg  = rnd_div(d_left + d_right, 2);
    dang = turn_angle(d_right - d_left, longint'(track_q));
    heading_trig(longint'($signed(heading)), c, s);
    pos_x += 32'(rnd_div(avg * c, 64'd1 << 30));
    pos_y += 32'(rnd_div(avg * s, 64'd1 << 30));
    heading += 32'(dang);
    res[0] = 32'(ticks_rad(lc));
    res[1] = 32'(ticks_rad(rc));
    res[2] = 32'(clip32(rnd_div(dl * 1000000, t)));
    res[3] = 32'(clip32(rnd_div(dr * 1000000, t)));
    res[4] = pos_x;
    res[5] = pos_y;
    res[6] = heading;
    res[7] = 32'(clip32(rnd_div(avg * 1000000, t)));
    res[8] = 32'(clip32(rnd_div(dang * 1000000, t)));
  endtask

  // Send one sample; valid stays high on return so back-to-back transfers work.
  task automatic send_sample(input logic [ENC_W-1:0] lc, input logic [ENC_W-1:0] rc,
                             input logic [TIME_W-1:0] us);
    pose_t res;
    if ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_if.valid       <= 1'b1;
    in_if.left_count  <= lc;
    in_if.right_count <= rc;
    in_if.elapsed_us  <= us;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    odometry_step(lc, rc, us, res);
    pending_poses.push_back(res);
    stim_left = lc;
    stim_right = rc;
  endtask

  // Drop valid and wait until the block has delivered everything.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_WHEEL_RADIUS:   radius_q = val[RADIUS_W-1:0];
      REG_WHEEL_TRACK:    track_q  = val[TRACK_W-1:0];
      REG_COUNTS_PER_REV: cpr_q    = val[CPR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int radius, input int track, input int cpr);
    write_reg(REG_WHEEL_RADIUS, CFG_DATA_W'(radius));
    write_reg(REG_WHEEL_TRACK, CFG_DATA_W'(track));
    write_reg(REG_COUNTS_PER_REV, CFG_DATA_W'(cpr));
  endtask

  // Mostly plausible wheel motion, with wrap jumps and pure noise mixed in.
  task automatic random_sample();
    int sel;
    logic [ENC_W-1:0] lc, rc;
    logic [TIME_W-1:0] us;
    sel = $urandom_range(99);
    if (sel < 70) begin
      lc = stim_left + ENC_W'($urandom_range(800) - 400);
      rc = stim_right + ENC_W'($urandom_range(800) - 400);
    end else if (sel < 80) begin
      lc = (stim_left < 16384) ? ENC_W'($urandom_range(32767, 31001))
                               : ENC_W'($urandom_range(999));
      rc = ($urandom_range(1)) ? ENC_W'($urandom_range(999))
                               : ENC_W'($urandom_range(32767, 31001));
    end else if (sel < 92) begin
      lc = ENC_W'($urandom);
      rc = ENC_W'($urandom);
    end else begin
      lc = stim_left;
      rc = stim_right;
    end
    sel = $urandom_range(99);
    if (sel < 70) us = TIME_W'($urandom_range(50000, 100));
    else if (sel < 80) us = TIME_W'($urandom_range(99));
    else if (sel < 90) us = TIME_W'($urandom);
    else us = TIME_W'($urandom_range(2000, 500));
    send_sample(lc, rc, us);
  endtask

  // Result checking against the oldest prediction.
  always @(posedge clk) begin
    if (in_if.valid && in_if.ready || out_if.valid && out_if.ready ||
        cfg_if.valid && cfg_if.ready) begin
      idle_watch <= 0;
    end else begin
      idle_watch <= idle_watch + 1;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      pose_t got, want;
      got = {out_if.turn_rate, out_if.forward_speed, out_if.heading_out, out_if.pose_y,
             out_if.pose_x, out_if.right_rate, out_if.left_rate, out_if.right_angle,
             out_if.left_angle};
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $time);
      end else begin
        want = pending_poses.pop_front();
        for (int f = 0; f < 9; f++) begin
          if (got[f] !== want[f]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%s mismatch at %0t: expected %0d, got %0d", field_names[f], $time,
                       $signed(want[f]), $signed(got[f]));
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (idle_watch >= WATCH_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result receiver with random stalls and an optional long hold-off.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Special cases: first sample, wraps both ways, short and huge intervals.
  task automatic test_directed();
    send_sample(100, 200, 1000);
    send_sample(100, 200, 1000);
    send_sample(150, 250, 1000);
    send_sample(250, 200, 2000);
    send_sample(600, 700, 0);
    send_sample(500, 32000, 99);
    send_sample(32000, 300, 100);
    send_sample(300, 32500, 5000);
    send_sample(0, 0, 24'hFFFFFF);
    send_sample(32767, 32767, 1000);
    send_sample(0, 0, 1000);
    send_sample(5000, 30000, 1);
    send_sample(30000, 5000, 20000);
    send_sample(20000, 20100, 10000);
    send_sample(20100, 20000, 10000);
    send_sample(21000, 21000, 10000);
    send_sample(22000, 22000, 10000);
    drain();
  endtask

  // Register extremes, including the zero values the block must tolerate.
  task automatic test_geometry_extremes();
    int settings [5][3] = '{'{65535, 1, 1}, '{1, 131071, 65535}, '{40000, 0, 0},
                            '{65535, 131071, 1}, '{3000, 20000, 100}};
    for (int k = 0; k < 5; k++) begin
      set_geometry(settings[k][0], settings[k][1], settings[k][2]);
      send_sample(0, 32767, 100);
      send_sample(32767, 0, 100);
      send_sample(16000, 16300, 200);
      send_sample(16000, 16000, 99);
      drain();
    end
  endtask

  task automatic test_random(input int items, input int s_idle, input int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (items) random_sample();
    drain();
  endtask

  // Output held off while samples keep coming, so the input stalls.
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1;
    repeat (12) random_sample();
    drain();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.left_count = '0;
    in_if.right_count = '0;
    in_if.elapsed_us = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    last_left = '0;
    last_right = '0;
    seen_sample = 1'b0;
    pos_x = '0;
    pos_y = '0;
    heading = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_geometry_extremes();
    set_geometry(5571, 18547, 756);
    test_random(500, 32, 82);
    set_geometry($urandom_range(65535, 1), $urandom_range(131071, 1),
                 $urandom_range(4096, 1));
    test_random(500, 82, 32);
    set_geometry($urandom_range(20000, 1000), $urandom_range(60000, 5000),
                 $urandom_range(2000, 100));
    test_random(450, 0, 0);
    test_backpressure();

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
